// ===== sv/bdtc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdtc_pkg: shared types and constants of the block DCT compressor
// Field widths, result limits, register reset value and the divisors
// used when the cosine table is built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package bdtc_pkg;

	localparam int KEEP_W     = 4;
	localparam int IDX_W      = 3;
	localparam int COEF_W     = 20;
	localparam int MAX_KEEP   = 8;
	localparam int KEEP_RESET = 4;
	localparam int COEF_MAX   = 524287;
	localparam int COEF_MIN   = -524288;

	// pi in Q30
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// Taylor series divisors (2i+1)(2i+2) for the cosine terms
	localparam int TAYLOR_TERMS = 14;
	localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
		64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
	};

	// pipeline control travelling with a sample
	typedef struct packed {
		logic valid;
		logic last;
	} bdtc_ctl_t;

endpackage

`default_nettype wire

// ===== sv/bdtc_mac.sv =====
// ----------------------------------------------------------------------------
// bdtc_mac: table multiply and coefficient accumulators
// Multiplies the staged sample by one table column, registers the
// products, then adds them into the accumulators. On the last sample of
// a block the completed sums are presented and the accumulators clear.
// ----------------------------------------------------------------------------
`default_nettype none

module bdtc_mac
	import bdtc_pkg::*;
#(
	parameter int BLOCK_LEN       = 8,
	parameter int SAMPLE_WIDTH    = 16,
	parameter int TABLE_FRAC_BITS = 14,
	localparam int NK    = (BLOCK_LEN < MAX_KEEP) ? BLOCK_LEN : MAX_KEEP,
	localparam int POS_W = $clog2(BLOCK_LEN),
	localparam int TW    = TABLE_FRAC_BITS + 2,
	localparam int PW    = SAMPLE_WIDTH + TW,
	localparam int ACC_W = PW + $clog2(BLOCK_LEN) + 1
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            advance,
	input  wire bdtc_ctl_t                 ctl_s1,
	input  wire signed [SAMPLE_WIDTH-1:0]  sample_s1,
	input  wire        [POS_W-1:0]         pos_s1,
	output logic                           done,
	output logic signed [ACC_W-1:0]        sums [NK]
);

	// integer square root, bit by bit
	function automatic longint unsigned isqrt64(input longint unsigned v_in);
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		v = v_in;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v)
				b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// cos(pi*m/(2*BLOCK_LEN)) in Q30
	function automatic longint cos_q30(input longint unsigned m_in);
		longint unsigned m;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		logic            neg;
		m   = m_in % (4 * BLOCK_LEN);
		neg = 1'b0;
		if (m > 2 * BLOCK_LEN)
			m = 4 * BLOCK_LEN - m;
		if (m > BLOCK_LEN) begin
			neg = 1'b1;
			m   = 2 * BLOCK_LEN - m;
		end
		x    = PI_Q30 * m / (2 * BLOCK_LEN);
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		acc  = longint'(term);
		for (int i = 0; i < TAYLOR_TERMS; i++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[i];
			if (i % 2 == 1)
				acc = acc + longint'(term);
			else
				acc = acc - longint'(term);
		end
		return neg ? -acc : acc;
	endfunction

	// orthonormal DCT-II entry, rounded half away from zero
	function automatic longint tab_entry(input int k, input int n);
		longint unsigned s;
		longint unsigned mag;
		longint unsigned r;
		longint          c;
		logic            neg;
		if (k == 0)
			s = isqrt64((64'd1 << 60) / BLOCK_LEN);
		else
			s = isqrt64((64'd1 << 61) / BLOCK_LEN);
		c   = cos_q30(longint'((2 * n + 1) * k));
		neg = (c < 0);
		mag = longint'(neg ? -c : c) * s;
		r   = (mag + (64'd1 << (59 - TABLE_FRAC_BITS))) >> (60 - TABLE_FRAC_BITS);
		return neg ? -longint'(r) : longint'(r);
	endfunction

	logic signed [TW-1:0]    tab_w  [NK][BLOCK_LEN];
	logic signed [PW-1:0]    prod_s2 [NK];
	logic signed [ACC_W-1:0] acc_q  [NK];
	bdtc_ctl_t               ctl_s2;

	for (genvar k = 0; k < NK; k++) begin : g_row
		for (genvar n = 0; n < BLOCK_LEN; n++) begin : g_col
			localparam logic signed [TW-1:0] ENTRY = TW'(tab_entry(k, n));
			assign tab_w[k][n] = ENTRY;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < NK; k++)
				prod_s2[k] <= sample_s1 * tab_w[k][pos_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			for (int k = 0; k < NK; k++)
				acc_q[k] <= '0;
		end else if (advance) begin
			ctl_s2 <= ctl_s1;
			if (ctl_s2.valid) begin
				for (int k = 0; k < NK; k++)
					acc_q[k] <= ctl_s2.last ? '0 : sums[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NK; k++)
			sums[k] = acc_q[k] + ACC_W'(prod_s2[k]);
	end

	assign done = ctl_s2.valid && ctl_s2.last;

endmodule

`default_nettype wire

// ===== sv/block_dct_truncating_compressor_top.sv =====
// ----------------------------------------------------------------------------
// block_dct_truncating_compressor_top: 8-point DCT-II with truncation
// Groups samples into blocks and emits the leading DCT coefficients of
// each block, rounded and saturated to Q19.0 (signed 20-bit integers).
//  - Sample channel: sample_valid / sample_stall / sample, one item per
//    cycle while sample_stall is low.
//  - Coefficient channel: coeff_valid / coeff_stall with coeff_index,
//    coefficient and last; last marks the final coefficient of a block.
//  - Config channel: cfg_valid / cfg_ready / cfg_data writes keep_count
//    (always ready). Write it only while no block is in progress.
//  - Flow: a block's first coefficient follows its last sample through the
//    sample stage, product register, bank and output register, then one
//    per cycle while coeff_stall is low. Throughput is one sample per cycle
//    unless stalled; the bank is refilled the cycle its final entry is read.
//  - Stall: the output register holds while the receiver stalls. The
//    input stalls only when a finished block finds the bank still busy.
//  - Reset: accumulators and position clear, keep_count returns to 4,
//    no items are pending.
// ----------------------------------------------------------------------------
`default_nettype none

module block_dct_truncating_compressor_top
	import bdtc_pkg::*;
#(
	parameter int BLOCK_LEN       = 8,
	parameter int SAMPLE_WIDTH    = 16,
	parameter int TABLE_FRAC_BITS = 14
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// sample channel
	input  wire                            sample_valid,
	output logic                           sample_stall,
	input  wire signed [SAMPLE_WIDTH-1:0]  sample,
	// coefficient channel
	output logic                           coeff_valid,
	input  wire                            coeff_stall,
	output logic       [IDX_W-1:0]         coeff_index,
	output logic signed [COEF_W-1:0]       coefficient,
	output logic                           last,
	// keep_count write
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire        [KEEP_W-1:0]        cfg_data
);

	localparam int NK     = (BLOCK_LEN < MAX_KEEP) ? BLOCK_LEN : MAX_KEEP;
	localparam int POS_W  = $clog2(BLOCK_LEN);
	localparam int BIDX_W = $clog2(NK);
	localparam int CNT_W  = $clog2(NK + 1);
	localparam int PW     = SAMPLE_WIDTH + TABLE_FRAC_BITS + 2;
	localparam int ACC_W  = PW + $clog2(BLOCK_LEN) + 1;
	localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) << (TABLE_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(COEF_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(COEF_MIN);

	// config
	logic [KEEP_W-1:0] keep_q;
	logic [CNT_W-1:0]  keep_eff;

	// sample stage
	logic                           accept_in;
	logic                           advance;
	logic [POS_W-1:0]               pos_q;
	logic [POS_W-1:0]               pos_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	bdtc_ctl_t                      ctl_s1;

	// accumulator results
	logic                    done;
	logic signed [ACC_W-1:0] sums [NK];

	// output bank and drain
	logic signed [ACC_W-1:0] bank_q [NK];
	logic [CNT_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    out_load;
	logic                    bank_free;
	logic                    bank_wr;
	logic signed [ACC_W-1:0] rnd_sum;
	logic signed [ACC_W-1:0] shifted;
	logic signed [COEF_W-1:0] sat_val;

	// output register
	logic                     coeff_valid_q;
	logic [IDX_W-1:0]         coeff_index_q;
	logic signed [COEF_W-1:0] coefficient_q;
	logic                     last_q;

	// ---------------- keep_count register ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_W'(KEEP_RESET);
		end else if (cfg_valid && cfg_ready) begin
			keep_q <= cfg_data;
		end
	end

	// zero means one, anything past the bank depth is clamped
	always_comb begin
		if (keep_q == '0)
			keep_eff = CNT_W'(1);
		else if (keep_q > KEEP_W'(NK))
			keep_eff = CNT_W'(NK);
		else
			keep_eff = CNT_W'(keep_q);
	end

	// ---------------- drain control ----------------
	// the bank can take a new block once its final entry is read
	assign out_load  = (cnt_q != '0) && (!coeff_valid_q || !coeff_stall);
	assign bank_free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_load);
	assign advance   = !(done && !bank_free);
	assign bank_wr   = advance && done;

	assign sample_stall = !advance;
	assign accept_in    = sample_valid && !sample_stall;

	// ---------------- sample stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1.valid <= accept_in;
			ctl_s1.last  <= (pos_q == POS_W'(BLOCK_LEN - 1));
			if (accept_in)
				pos_q <= (pos_q == POS_W'(BLOCK_LEN - 1)) ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_s1 <= sample;
			pos_s1    <= pos_q;
		end
	end

	bdtc_mac #(
		.BLOCK_LEN       (BLOCK_LEN),
		.SAMPLE_WIDTH    (SAMPLE_WIDTH),
		.TABLE_FRAC_BITS (TABLE_FRAC_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.ctl_s1    (ctl_s1),
		.sample_s1 (sample_s1),
		.pos_s1    (pos_s1),
		.done      (done),
		.sums      (sums)
	);

	// ---------------- coefficient bank ----------------
	always_ff @(posedge clk) begin
		if (bank_wr) begin
			for (int k = 0; k < NK; k++)
				bank_q[k] <= sums[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (bank_wr) begin
			cnt_q <= keep_eff;
			idx_q <= '0;
		end else if (out_load) begin
			cnt_q <= cnt_q - 1'b1;
			idx_q <= idx_q + 1'b1;
		end
	end

	// round half up, floor shift, saturate to 20 bits
	always_comb begin
		rnd_sum = bank_q[idx_q[BIDX_W-1:0]] + RND;
		shifted = rnd_sum >>> TABLE_FRAC_BITS;
		if (shifted > SAT_HI)
			sat_val = COEF_W'(COEF_MAX);
		else if (shifted < SAT_LO)
			sat_val = COEF_W'(COEF_MIN);
		else
			sat_val = shifted[COEF_W-1:0];
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_valid_q <= 1'b0;
		end else if (out_load) begin
			coeff_valid_q <= 1'b1;
		end else if (!coeff_stall) begin
			coeff_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			coeff_index_q <= idx_q;
			coefficient_q <= sat_val;
			last_q        <= (cnt_q == CNT_W'(1));
		end
	end

	assign coeff_valid = coeff_valid_q;
	assign coeff_index = coeff_index_q;
	assign coefficient = coefficient_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_block_dct_truncating_compressor_top.sv =====
// ----------------------------------------------------------------------------
// tb_block_dct_truncating_compressor_top: self-checking bench for the DCT
// Streams signed samples into the compressor and predicts every emitted
// coefficient with an integer DCT-II built in the bench. Sweeps keep_count
// across its extremes and applies random idle and backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_block_dct_truncating_compressor_top
	import bdtc_pkg::*;
();

	localparam int SAMPLE_W   = 16;
	localparam int BLK        = 8;
	localparam int FRAC       = 14;
	localparam int IDLE_LIMIT = 3000;    // cycles with no handshake at all
	localparam int HOLD_CYC   = 90;      // long receiver hold-off
	localparam int SETTLE_CYC = 12;      // pipeline quiet time before a cfg write

	// one coefficient item as seen on the output channel
	typedef struct {
		logic [IDX_W-1:0]         index;
		logic signed [COEF_W-1:0] value;
		logic                     last;
	} coeff_t;

	// ------------------------------------------------------------------
	// Tracks the block DCT: own cosine basis, accumulators, block
	// position and keep_count. Queues the coefficients each finished
	// block must produce and checks arrivals against them in order.
	// ------------------------------------------------------------------
	class dct_coeff_tracker;
		longint          basis [BLK][BLK];
		longint          acc [BLK];
		int unsigned     pos;
		logic [KEEP_W-1:0] keep_raw;
		coeff_t          coeffs_due [$];
		int unsigned     failures;
		int unsigned     checked;
		int unsigned     samples;
		int unsigned     blocks;

		function new();
			build_basis();
			foreach (acc[k])
				acc[k] = 0;
			pos      = 0;
			keep_raw = KEEP_W'(KEEP_RESET);
			failures = 0;
			checked  = 0;
			samples  = 0;
			blocks   = 0;
		endfunction

		// bitwise integer square root
		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		// cos(pi*m/(2*BLK)) in Q30 via folded Taylor series
		function longint cos_q30(longint unsigned m);
			longint unsigned x;
			longint unsigned x2;
			longint unsigned term;
			longint          sum;
			bit              neg;
			neg = 0;
			m = m % (4 * BLK);
			if (m > 2 * BLK)
				m = 4 * BLK - m;
			if (m > BLK) begin
				neg = 1;
				m = 2 * BLK - m;
			end
			x    = PI_Q30 * m / (2 * BLK);
			x2   = (x * x) >> 30;
			term = 64'd1 << 30;
			sum  = longint'(term);
			for (int i = 0; i < 14; i++) begin
				term = ((term * x2) >> 30) / longint'((2 * i + 1) * (2 * i + 2));
				if (i % 2 == 1)
					sum = sum + longint'(term);
				else
					sum = sum - longint'(term);
			end
			return neg ? -sum : sum;
		endfunction

		// orthonormal DCT-II basis in Q1.14, rounded half away from zero
		function void build_basis();
			longint unsigned scale;
			longint unsigned mag;
			longint unsigned r;
			longint          c;
			for (int k = 0; k < BLK; k++) begin
				scale = int_sqrt(((k == 0) ? (64'd1 << 60) : (64'd1 << 61)) / BLK);
				for (int n = 0; n < BLK; n++) begin
					c   = cos_q30(longint'((2 * n + 1) * k));
					mag = longint'((c < 0) ? -c : c) * scale;
					r   = (mag + (64'd1 << (60 - FRAC - 1))) >> (60 - FRAC);
					basis[k][n] = (c < 0) ? -longint'(r) : longint'(r);
				end
			end
		endfunction

		function void set_keep(logic [KEEP_W-1:0] v);
			keep_raw = v;
		endfunction

		function int unsigned outstanding();
			return coeffs_due.size();
		endfunction

		// accepted sample: accumulate, and on the block's last one queue
		// the leading coefficients
		function void take_sample(logic signed [SAMPLE_W-1:0] s);
			int unsigned n;
			longint      v;
			coeff_t      c;
			samples++;
			for (int k = 0; k < BLK; k++)
				acc[k] += longint'(s) * basis[k][pos];
			if (pos + 1 < BLK) begin
				pos++;
				return;
			end
			n = keep_raw;
			if (n < 1)
				n = 1;
			if (n > BLK)
				n = BLK;
			if (n > MAX_KEEP)
				n = MAX_KEEP;
			for (int k = 0; k < n; k++) begin
				// round half up, then clip to Q19.0
				v = (acc[k] + (longint'(1) << (FRAC - 1))) >>> FRAC;
				if (v > COEF_MAX)
					v = COEF_MAX;
				if (v < COEF_MIN)
					v = COEF_MIN;
				c.index = IDX_W'(k);
				c.value = v[COEF_W-1:0];
				c.last  = (k + 1 == n);
				coeffs_due.push_back(c);
			end
			foreach (acc[k])
				acc[k] = 0;
			pos = 0;
			blocks++;
		endfunction

		function void check_coeff(logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] val,
				logic lst);
			coeff_t want;
			checked++;
			if (coeffs_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected coefficient: index %0d value %0d last %0b",
						idx, val, lst);
				return;
			end
			want = coeffs_due.pop_front();
			if (idx !== want.index || val !== want.value || lst !== want.last) begin
				failures++;
				if (failures <= 10)
					$display("coeff mismatch: exp %0d/%0d/%0b, got %0d/%0d/%0b",
						want.index, want.value, want.last, idx, val, lst);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT hookup; every input has a known value from time zero
	// ------------------------------------------------------------------
	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        sample_valid = 1'b0;
	logic                        sample_stall;
	logic signed [SAMPLE_W-1:0]  sample       = '0;
	logic                        coeff_valid;
	logic                        coeff_stall  = 1'b0;
	logic [IDX_W-1:0]            coeff_index;
	logic signed [COEF_W-1:0]    coefficient;
	logic                        last;
	logic                        cfg_valid    = 1'b0;
	logic                        cfg_ready;
	logic [KEEP_W-1:0]           cfg_data     = '0;

	block_dct_truncating_compressor_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.coeff_valid  (coeff_valid),
		.coeff_stall  (coeff_stall),
		.coeff_index  (coeff_index),
		.coefficient  (coefficient),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	dct_coeff_tracker sb;

	// calm: no idling on either side; hold_request: receiver hold-off length
	bit          calm         = 0;
	int unsigned hold_request = 0;
	int unsigned idle_cycles  = 0;
	int unsigned input_backed = 0;

	// mostly zero or short, now and then a long gap
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// full-scale corners, small values near zero, otherwise anything
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				return {1'b0, {(SAMPLE_W-1){1'b1}}};
			end
			1: begin
				return {1'b1, {(SAMPLE_W-1){1'b0}}};
			end
			2, 3: begin
				return SAMPLE_W'($signed($urandom_range(0, 127)) - 64);
			end
			default: begin
				return SAMPLE_W'($urandom());
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sample side. Called at a rising edge; returns at the edge where
	// the item was taken, valid still high for a back-to-back follow-up.
	// ------------------------------------------------------------------
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
		sample_valid <= 1'b1;
		sample       <= v;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sb.take_sample(v);
	endtask

	task automatic pause_sender();
		int unsigned g;
		g = calm ? 0 : pick_gap();
		if (g != 0) begin
			sample_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// keep_count only changes with the pipeline empty: drain what is
	// due, let the last block's tail settle, then write
	task automatic write_keep(input logic [KEEP_W-1:0] v);
		sample_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_keep(v);
	endtask

	// ------------------------------------------------------------------
	// Coefficient side: checks every taken item and decides the stall
	// for the next cycle. A hold request is counted down here.
	// ------------------------------------------------------------------
	initial begin : rx_side
		int unsigned stall_run;
		stall_run = 0;
		forever begin
			@(posedge clk);
			if (arst_n && coeff_valid && !coeff_stall)
				sb.check_coeff(coeff_index, coefficient, last);
			if (hold_request != 0) begin
				stall_run    = hold_request;
				hold_request = 0;
			end else if (stall_run == 0 && !calm && $urandom_range(0, 99) < 15)
				stall_run = pick_gap();
			if (stall_run != 0) begin
				coeff_stall <= 1'b1;
				stall_run--;
			end else
				coeff_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any handshake restarts the count
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_stall)
				input_backed <= input_backed + 1;
			if ((sample_valid && !sample_stall) || (coeff_valid && !coeff_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles == IDLE_LIMIT) begin
					$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
					$display("tb_block_dct_truncating_compressor_top NOT OK");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [KEEP_W-1:0] keep_plan [5];
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed blocks at the reset keep_count: positive full scale
		// (big DC), negative full scale, and a full-swing alternation that
		// drives the highest frequency
		for (int j = 0; j < BLK; j++) begin
			send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
			pause_sender();
		end
		for (int j = 0; j < BLK; j++) begin
			send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
			pause_sender();
		end
		for (int j = 0; j < BLK; j++) begin
			send_sample((j % 2 == 0) ? {1'b0, {(SAMPLE_W-1){1'b1}}} :
				{1'b1, {(SAMPLE_W-1){1'b0}}});
			pause_sender();
		end

		// keep_count sweep: single coefficient, all eight, zero (acts as
		// one), all ones (clamps to eight), then something in between.
		// The full-keep phase runs with no idling on either side.
		keep_plan = '{KEEP_W'(1), KEEP_W'(8), KEEP_W'(0), KEEP_W'(15),
			KEEP_W'($urandom_range(2, 7))};
		for (int ph = 0; ph < 5; ph++) begin
			write_keep(keep_plan[ph]);
			calm = (ph == 1);
			for (int b = 0; b < 3; b++)
				for (int j = 0; j < BLK; j++) begin
					send_sample(pick_sample());
					pause_sender();
				end
		end

		// backpressure: receiver holds off while samples keep coming
		// back to back, so the coefficient bank fills and the input stalls
		write_keep(KEEP_W'(8));
		calm = 1;
		hold_request = HOLD_CYC;
		for (int j = 0; j < 4 * BLK; j++)
			send_sample(pick_sample());
		sample_valid <= 1'b0;
		calm = 0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("run: %0d samples in %0d blocks, %0d coefficients checked, %0d failures",
			sb.samples, sb.blocks, sb.checked, sb.failures);
		$display("keep_count swept 4/1/8/0/15/mid/8; input backed up for %0d cycles",
			input_backed);
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("tb_block_dct_truncating_compressor_top OK");
		else
			$display("tb_block_dct_truncating_compressor_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
